// File: src/imhq_pkg.sv
// imhq_pkg: shared types and constants of the indexed min-heap queue
// used by imhq_store and indexed_min_heap_queue; depends on nothing
package imhq_pkg;

  localparam int unsigned CAPACITY  = 256;
  localparam int unsigned DIST_BITS = 24;
  localparam int unsigned VTX_BITS  = 8;
  localparam int unsigned VTX_COUNT = 1 << VTX_BITS;
  localparam int unsigned SLOT_BITS = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_BITS  = $clog2(CAPACITY);

  // operation kinds
  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_EXTRACT = 2'd1;
  localparam logic [1:0] KIND_UPDATE  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_QUEUED = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;

  typedef struct packed {
    logic [1:0]           kind;
    logic [VTX_BITS-1:0]  vertex;
    logic [DIST_BITS-1:0] new_dist;
  } in_req_t;

  typedef struct packed {
    logic [VTX_BITS-1:0]  out_vertex;
    logic [DIST_BITS-1:0] out_dist;
    logic [2:0]           status;
    logic [SLOT_BITS-1:0] entry_total;
  } out_res_t;

  typedef struct packed {
    logic [VTX_BITS-1:0]  vtx;
    logic [DIST_BITS-1:0] dval;
  } heap_ent_t;

  // access bundle from the controller to the storage
  typedef struct packed {
    logic [IDX_BITS-1:0]  hp_ra;
    logic [IDX_BITS-1:0]  hp_rb;
    logic                 hp_we;
    logic [IDX_BITS-1:0]  hp_wa;
    heap_ent_t            hp_wd;
    logic [VTX_BITS-1:0]  pm_ra;
    logic                 pm_we;
    logic [VTX_BITS-1:0]  pm_wa;
    logic [SLOT_BITS-1:0] pm_wd;
  } mem_cmd_t;

endpackage

// File: src/indexed_min_heap_queue.sv
// indexed_min_heap_queue: top level, request decode and sift sequencer
// depends on imhq_pkg and imhq_store
//
// Indexed binary min-heap of (vertex, distance) entries. A request is taken
// when start is high and busy is low; the single result appears on out_res
// for one cycle with out_strobe and must be captured then. Each request passes
// through the idle and decode states, then for each heap level walked a read
// of the heap memory, then a compare and a write-back, and a final step that
// places the moving entry; update sifts up, then down. The position map starts
// empty after reset with no clearing pass.
module indexed_min_heap_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  imhq_pkg::in_req_t  in_req,
  output logic               out_strobe,
  output imhq_pkg::out_res_t out_res
);

  localparam int unsigned SB = imhq_pkg::SLOT_BITS;
  localparam int unsigned IB = imhq_pkg::IDX_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_UP_RD  = 3'd2;
  localparam logic [2:0] S_UP_CMP = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;

  logic [2:0]          state_r, state_nxt;
  imhq_pkg::in_req_t   req_r, req_nxt;
  logic [SB-1:0]       count_r, count_nxt;
  logic [SB-1:0]       k_r, k_nxt;
  imhq_pkg::heap_ent_t mv_r, mv_nxt;
  logic                upd_r, upd_nxt;
  imhq_pkg::out_res_t  res_r, res_nxt;
  logic                strobe_r, strobe_nxt;

  imhq_pkg::mem_cmd_t  cmd;
  imhq_pkg::heap_ent_t hp_qa, hp_qb, child;
  logic [SB-1:0]       pm_q, kk, j;
  logic [SB-1:0]       cap;

  imhq_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .hp_qa (hp_qa),
    .hp_qb (hp_qb),
    .pm_q  (pm_q)
  );

  assign cap = SB'(imhq_pkg::CAPACITY);
  assign kk  = {k_r[SB-2:0], 1'b0};
  // right child only when it exists and the left is strictly greater
  assign j     = ((kk < count_r) && (hp_qa.dval > hp_qb.dval)) ? kk + SB'(1) : kk;
  assign child = (j == kk) ? hp_qa : hp_qb;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    mv_nxt     = mv_r;
    upd_nxt    = upd_r;
    res_nxt    = res_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    cmd.hp_ra  = '0;
    cmd.hp_rb  = IB'(count_r - SB'(1));
    cmd.pm_ra  = in_req.vertex;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        res_nxt.out_vertex  = req_r.vertex;
        res_nxt.out_dist    = req_r.new_dist;
        res_nxt.status      = imhq_pkg::ST_OK;
        res_nxt.entry_total = count_r;
        mv_nxt.vtx          = req_r.vertex;
        mv_nxt.dval         = req_r.new_dist;
        upd_nxt             = 1'b0;
        state_nxt           = S_IDLE;
        case (req_r.kind)
          imhq_pkg::KIND_INSERT: begin
            if (pm_q != '0) begin
              res_nxt.status = imhq_pkg::ST_QUEUED;
              strobe_nxt     = 1'b1;
            end else if (count_r >= cap) begin
              res_nxt.status = imhq_pkg::ST_FULL;
              strobe_nxt     = 1'b1;
            end else begin
              count_nxt           = count_r + SB'(1);
              res_nxt.entry_total = count_r + SB'(1);
              k_nxt               = count_r + SB'(1);
              state_nxt           = S_UP_RD;
            end
          end
          imhq_pkg::KIND_EXTRACT: begin
            if (count_r == '0) begin
              res_nxt.status     = imhq_pkg::ST_EMPTY;
              res_nxt.out_vertex = '0;
              res_nxt.out_dist   = '0;
              strobe_nxt         = 1'b1;
            end else begin
              res_nxt.out_vertex  = hp_qa.vtx;
              res_nxt.out_dist    = hp_qa.dval;
              res_nxt.entry_total = count_r - SB'(1);
              count_nxt           = count_r - SB'(1);
              cmd.pm_we           = 1'b1;
              cmd.pm_wa           = hp_qa.vtx;
              cmd.pm_wd           = '0;
              if (count_r > SB'(1)) begin
                mv_nxt    = hp_qb;
                k_nxt     = SB'(1);
                state_nxt = S_DN_RD;
              end else begin
                strobe_nxt = 1'b1;
              end
            end
          end
          imhq_pkg::KIND_UPDATE: begin
            if (pm_q == '0 || pm_q > count_r) begin
              res_nxt.status = imhq_pkg::ST_ABSENT;
              strobe_nxt     = 1'b1;
            end else begin
              k_nxt     = pm_q;
              upd_nxt   = 1'b1;
              state_nxt = S_UP_RD;
            end
          end
          default: begin
            strobe_nxt = 1'b1;
          end
        endcase
      end

      S_UP_RD: begin
        cmd.hp_ra = IB'((k_r >> 1) - SB'(1));
        if (k_r > SB'(1)) begin
          state_nxt = S_UP_CMP;
        end else begin
          cmd.hp_we = 1'b1;
          cmd.hp_wa = IB'(k_r - SB'(1));
          cmd.hp_wd = mv_r;
          cmd.pm_we = 1'b1;
          cmd.pm_wa = mv_r.vtx;
          cmd.pm_wd = k_r;
          if (upd_r) begin
            state_nxt = S_DN_RD;
          end else begin
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_UP_CMP: begin
        cmd.hp_we = 1'b1;
        cmd.hp_wa = IB'(k_r - SB'(1));
        cmd.pm_we = 1'b1;
        cmd.pm_wd = k_r;
        // parent not smaller: pull it down and climb
        if (hp_qa.dval >= mv_r.dval) begin
          cmd.hp_wd = hp_qa;
          cmd.pm_wa = hp_qa.vtx;
          k_nxt     = k_r >> 1;
          state_nxt = S_UP_RD;
        end else begin
          cmd.hp_wd = mv_r;
          cmd.pm_wa = mv_r.vtx;
          if (upd_r) begin
            state_nxt = S_DN_RD;
          end else begin
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_DN_RD: begin
        cmd.hp_ra = IB'(kk - SB'(1));
        cmd.hp_rb = IB'(kk);
        if (k_r <= (count_r >> 1)) begin
          state_nxt = S_DN_CMP;
        end else begin
          cmd.hp_we  = 1'b1;
          cmd.hp_wa  = IB'(k_r - SB'(1));
          cmd.hp_wd  = mv_r;
          cmd.pm_we  = 1'b1;
          cmd.pm_wa  = mv_r.vtx;
          cmd.pm_wd  = k_r;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_DN_CMP: begin
        cmd.hp_we = 1'b1;
        cmd.hp_wa = IB'(k_r - SB'(1));
        cmd.pm_we = 1'b1;
        cmd.pm_wd = k_r;
        // child smaller: lift it and descend
        if (mv_r.dval > child.dval) begin
          cmd.hp_wd = child;
          cmd.pm_wa = child.vtx;
          k_nxt     = j;
          state_nxt = S_DN_RD;
        end else begin
          cmd.hp_wd  = mv_r;
          cmd.pm_wa  = mv_r.vtx;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
      upd_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      upd_r    <= upd_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    k_r   <= k_nxt;
    mv_r  <= mv_nxt;
    res_r <= res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

// File: src/imhq_store.sv
// imhq_store: heap slot memory (two read ports) and vertex position map
// depends on imhq_pkg; map entries carry valid bits so reset reads as absent
module imhq_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  imhq_pkg::mem_cmd_t              cmd,
  output imhq_pkg::heap_ent_t             hp_qa,
  output imhq_pkg::heap_ent_t             hp_qb,
  output logic [imhq_pkg::SLOT_BITS-1:0]  pm_q
);

  imhq_pkg::heap_ent_t            heap_mem [imhq_pkg::CAPACITY];
  logic [imhq_pkg::SLOT_BITS-1:0] pos_mem  [imhq_pkg::VTX_COUNT];
  logic [imhq_pkg::VTX_COUNT-1:0] pos_vld_r;
  logic [imhq_pkg::SLOT_BITS-1:0] pos_data_r;
  logic                           pos_hit_r;

  // heap memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.hp_we) begin
      heap_mem[cmd.hp_wa] <= cmd.hp_wd;
    end
    hp_qa <= heap_mem[cmd.hp_ra];
    hp_qb <= heap_mem[cmd.hp_rb];
  end

  // position map data, zero slot means absent
  always_ff @(posedge clk) begin
    if (cmd.pm_we) begin
      pos_mem[cmd.pm_wa] <= cmd.pm_wd;
    end
    pos_data_r <= pos_mem[cmd.pm_ra];
  end

  // valid bits cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0;
      pos_hit_r <= 1'b0;
    end else begin
      if (cmd.pm_we) begin
        pos_vld_r[cmd.pm_wa] <= (cmd.pm_wd != '0);
      end
      pos_hit_r <= pos_vld_r[cmd.pm_ra];
    end
  end

  assign pm_q = pos_hit_r ? pos_data_r : '0;

endmodule

// File: verif/indexed_min_heap_queue_tb.sv
// indexed_min_heap_queue_tb: self-checking bench for the indexed min-heap queue
// depends on imhq_pkg and indexed_min_heap_queue; predicts every result in-bench
`timescale 1ns / 100ps

module indexed_min_heap_queue_tb;

  localparam int WATCHDOG_CYCLES = 20000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  imhq_pkg::in_req_t  in_req;
  logic               out_strobe;
  imhq_pkg::out_res_t out_res;

  indexed_min_heap_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

  // predicted heap state
  imhq_pkg::heap_ent_t            model_heap [1:imhq_pkg::CAPACITY];
  logic [imhq_pkg::SLOT_BITS-1:0] model_pos  [0:imhq_pkg::VTX_COUNT-1] = '{default: '0};
  int unsigned                    model_count = 0;

  imhq_pkg::in_req_t  pending_reqs [$];
  imhq_pkg::out_res_t expected_res [$];
  int                 fail_count = 0;
  int                 idle_pct;
  int                 quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void heap_place(int unsigned k, imhq_pkg::heap_ent_t e);
    model_heap[k] = e;
    model_pos[e.vtx] = imhq_pkg::SLOT_BITS'(k);
  endfunction

  function automatic void sift_up_at(int unsigned k);
    imhq_pkg::heap_ent_t mv;
    mv = model_heap[k];
    while (k > 1 && model_heap[k/2].dval >= mv.dval) begin
      heap_place(k, model_heap[k/2]);
      k = k / 2;
    end
    heap_place(k, mv);
  endfunction

  function automatic void sift_down_at(int unsigned k);
    imhq_pkg::heap_ent_t mv;
    int unsigned         j;
    mv = model_heap[k];
    while (k <= model_count / 2) begin
      j = 2 * k;
      if (j < model_count && model_heap[j].dval > model_heap[j+1].dval) j++;
      if (mv.dval <= model_heap[j].dval) break;
      heap_place(k, model_heap[j]);
      k = j;
    end
    heap_place(k, mv);
  endfunction

  // work out the result of one accepted request and update the state
  function automatic imhq_pkg::out_res_t heap_predict(imhq_pkg::in_req_t rq);
    imhq_pkg::out_res_t  r;
    int unsigned         p;
    imhq_pkg::heap_ent_t e;
    r.out_vertex = rq.vertex;
    r.out_dist   = rq.new_dist;
    r.status     = imhq_pkg::ST_OK;
    case (rq.kind)
      imhq_pkg::KIND_INSERT: begin
        if (model_pos[rq.vertex] != 0) r.status = imhq_pkg::ST_QUEUED;
        else if (model_count >= imhq_pkg::CAPACITY) r.status = imhq_pkg::ST_FULL;
        else begin
          model_count++;
          e.vtx  = rq.vertex;
          e.dval = rq.new_dist;
          heap_place(model_count, e);
          sift_up_at(model_count);
        end
      end
      imhq_pkg::KIND_EXTRACT: begin
        if (model_count == 0) begin
          r.status     = imhq_pkg::ST_EMPTY;
          r.out_vertex = '0;
          r.out_dist   = '0;
        end else begin
          e = model_heap[1];
          r.out_vertex = e.vtx;
          r.out_dist   = e.dval;
          model_pos[e.vtx] = '0;
          model_count--;
          if (model_count > 0) begin
            heap_place(1, model_heap[model_count+1]);
            sift_down_at(1);
          end
        end
      end
      imhq_pkg::KIND_UPDATE: begin
        p = int'(model_pos[rq.vertex]);
        if (p == 0 || p > model_count) r.status = imhq_pkg::ST_ABSENT;
        else begin
          model_heap[p].dval = rq.new_dist;
          sift_up_at(p);
          sift_down_at(int'(model_pos[rq.vertex]));
        end
      end
      default: ;
    endcase
    r.entry_total = imhq_pkg::SLOT_BITS'(model_count);
    return r;
  endfunction

  function automatic imhq_pkg::in_req_t mk_req(logic [1:0] k, int v, int d);
    imhq_pkg::in_req_t rq;
    rq.kind     = k;
    rq.vertex   = imhq_pkg::VTX_BITS'(v);
    rq.new_dist = imhq_pkg::DIST_BITS'(d);
    return rq;
  endfunction

  // weighted random request; vertices kept in a narrow range sometimes for hits
  function automatic imhq_pkg::in_req_t rand_req(int vmax);
    int      w;
    logic [1:0] k;
    int      d;
    w = $urandom_range(99);
    if (w < 45) k = imhq_pkg::KIND_INSERT;
    else if (w < 75) k = imhq_pkg::KIND_EXTRACT;
    else if (w < 97) k = imhq_pkg::KIND_UPDATE;
    else k = 2'd3;
    case ($urandom_range(3))
      0: d = $urandom_range(15);
      1: d = $urandom_range(255);
      default: d = $urandom & 24'hFFFFFF;
    endcase
    return mk_req(k, $urandom_range(vmax), d);
  endfunction

  // driver: present pending requests, sender idling at idle_pct
  always @(posedge clk) begin
    if (!rst_n) begin
      start  <= 1'b0;
      in_req <= '0;
    end else if (start && busy) begin
      // hold the request until taken
    end else begin
      if (start) begin
        expected_res.push_back(heap_predict(in_req));
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start  <= 1'b1;
        in_req <= pending_reqs.pop_front();
      end else begin
        start  <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    imhq_pkg::out_res_t want;
    if (rst_n && out_strobe) begin
      if (expected_res.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = expected_res.pop_front();
        if (out_res.out_vertex !== want.out_vertex) begin
          $error("out_vertex exp %0d got %0d", want.out_vertex, out_res.out_vertex);
          fail_count++;
        end
        if (out_res.out_dist !== want.out_dist) begin
          $error("out_dist exp %0d got %0d", want.out_dist, out_res.out_dist);
          fail_count++;
        end
        if (out_res.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_res.status);
          fail_count++;
        end
        if (out_res.entry_total !== want.entry_total) begin
          $error("entry_total exp %0d got %0d", want.entry_total, out_res.entry_total);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no request and no result taken
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("indexed_min_heap_queue regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_res.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int n;
    int phase;
    idle_pct = 0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty extract, extremes, duplicates, absent update, kind 3
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_EXTRACT, 255, 24'hFFFFFF));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_UPDATE, 7, 5));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_INSERT, 0, 0));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_INSERT, 255, 24'hFFFFFF));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_INSERT, 0, 9));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_INSERT, 170, 24'hAAAAAA));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_INSERT, 85, 24'h555555));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_INSERT, 86, 24'h555555));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_UPDATE, 255, 1));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_UPDATE, 0, 24'hFFFFFF));
    pending_reqs.push_back(mk_req(2'd3, 170, 24'h123456));
    for (int i = 0; i < 7; i++)
      pending_reqs.push_back(mk_req(imhq_pkg::KIND_EXTRACT, 0, 0));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_UPDATE, 170, 3));

    // fill to capacity, some with equal distances, re-insert a queued vertex, update, then drain
    for (int v = 0; v < imhq_pkg::VTX_COUNT; v++)
      pending_reqs.push_back(mk_req(imhq_pkg::KIND_INSERT, v,
                                    ($urandom_range(3) == 0) ? 100
                                                             : $urandom & 24'hFFFFFF));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_INSERT, 12, 4));
    pending_reqs.push_back(mk_req(imhq_pkg::KIND_INSERT, 12, 4));
    for (int i = 0; i < 40; i++)
      pending_reqs.push_back(mk_req(imhq_pkg::KIND_UPDATE,
                                    $urandom_range(255), $urandom & 24'hFFFFFF));
    for (int i = 0; i < imhq_pkg::VTX_COUNT + 1; i++)
      pending_reqs.push_back(mk_req(imhq_pkg::KIND_EXTRACT, $urandom_range(255), $urandom));
    wait_drained();

    // random phases with different sender idling
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 18;
        default: idle_pct = 0;
      endcase
      n = 0;
      while (n < 400) begin
        pending_reqs.push_back(rand_req((phase == 1) ? 15 : 255));
        n++;
      end
      wait_drained();
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("indexed_min_heap_queue regression: pass");
    else $display("indexed_min_heap_queue regression: fail");
    $finish;
  end

endmodule

// File: sim.f
src/imhq_pkg.sv
src/imhq_store.sv
src/indexed_min_heap_queue.sv
verif/indexed_min_heap_queue_tb.sv
